/* sv/qfs_pkg.sv */
// Types, codes and helper functions shared by the quoted field splitter.
// Used by the parser, the result queue, the top level and the testbench.
package qfs_pkg;

    localparam logic [1:0] ERR_NONE          = 2'd0;
    localparam logic [1:0] ERR_MISSING_QUOTE = 2'd1;
    localparam logic [1:0] ERR_BAD_SEPARATOR = 2'd2;

    localparam logic REG_QUOTE_CHAR = 1'b0;
    localparam logic REG_SEPARATOR  = 1'b1;

    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    typedef enum logic [4:0] {
        MODE_LINE_START  = 5'b00001,
        MODE_FIELD_START = 5'b00010,
        MODE_UNQUOTED    = 5'b00100,
        MODE_QUOTED      = 5'b01000,
        MODE_AFTER_CLOSE = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       field_end;
        logic       line_end;
        logic [1:0] error_code;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       two;
        result_t    first;
        result_t    second;
    } decode_t;

    function automatic result_t res_byte(input logic [7:0] b);
        result_t r;
        r.out_byte   = b;
        r.field_end  = 1'b0;
        r.line_end   = 1'b0;
        r.error_code = ERR_NONE;
        return r;
    endfunction

    function automatic result_t res_end(input logic le, input logic [1:0] err);
        result_t r;
        r.out_byte   = 8'd0;
        r.field_end  = 1'b1;
        r.line_end   = le;
        r.error_code = err;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

/* sv/qfs_if.sv */
// Valid/ready channel interfaces for line bytes in and parsed results out.
// Depends on nothing else.
interface qfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface qfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       field_end;
    logic       line_end;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output field_end, output line_end,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input field_end, input line_end,
                    input error_code, output ready);
endinterface

/* sv/qfs_parser.sv */
// Input register, parse mode register and the per-byte decode logic.
// Depends on qfs_pkg and qfs_in_if.
module qfs_parser
(
    input  logic             clk,
    input  logic             rst_n,
    qfs_in_if.sink           in_ch,
    input  logic [7:0]       quote_char,
    input  logic [7:0]       separator,
    input  logic             room,
    output qfs_pkg::decode_t dec
);

    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    qfs_pkg::mode_t    mode_reg;
    qfs_pkg::mode_t    mode_next;
    logic              fire;
    qfs_pkg::result_t  fs_first;
    logic              fs_two;
    qfs_pkg::mode_t    fs_mode;

    assign fire        = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= qfs_pkg::MODE_LINE_START;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (fire)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            byte_reg <= in_ch.data_byte;
            last_reg <= in_ch.last_byte;
        end
    end

    // Handling of a byte at the start of a field.
    always_comb
    begin
        fs_two    = 1'b0;
        if (byte_reg == quote_char)
        begin
            fs_mode = qfs_pkg::MODE_QUOTED;
            if (last_reg)
            begin
                fs_first = qfs_pkg::res_end(1'b1, qfs_pkg::ERR_MISSING_QUOTE);
            end
            else
            begin
                fs_first = qfs_pkg::res_byte(byte_reg);
            end
        end
        else if (byte_reg == separator)
        begin
            fs_mode  = qfs_pkg::MODE_FIELD_START;
            fs_first = qfs_pkg::res_end(1'b0, qfs_pkg::ERR_NONE);
            fs_two   = last_reg;
        end
        else
        begin
            fs_mode  = qfs_pkg::MODE_UNQUOTED;
            fs_first = qfs_pkg::res_byte(byte_reg);
            fs_two   = last_reg;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        dec.push   = fire;
        dec.two    = 1'b0;
        dec.first  = qfs_pkg::res_byte(byte_reg);
        dec.second = qfs_pkg::res_end(1'b1, qfs_pkg::ERR_NONE);
        case (mode_reg)
            qfs_pkg::MODE_LINE_START:
            begin
                if (qfs_pkg::is_ws(byte_reg))
                begin
                    if (last_reg)
                    begin
                        dec.two   = (byte_reg == separator);
                        dec.first = qfs_pkg::res_end(byte_reg != separator,
                                                     qfs_pkg::ERR_NONE);
                    end
                    else
                    begin
                        dec.push  = 1'b0;
                        mode_next = qfs_pkg::MODE_FIELD_START;
                    end
                end
                else
                begin
                    dec.first = fs_first;
                    dec.two   = fs_two;
                    mode_next = fs_mode;
                end
            end
            qfs_pkg::MODE_UNQUOTED:
            begin
                dec.two = last_reg;
                if (byte_reg == separator)
                begin
                    dec.first = qfs_pkg::res_end(1'b0, qfs_pkg::ERR_NONE);
                    mode_next = qfs_pkg::MODE_FIELD_START;
                end
            end
            qfs_pkg::MODE_QUOTED:
            begin
                if (byte_reg == quote_char)
                begin
                    dec.two   = last_reg;
                    mode_next = qfs_pkg::MODE_AFTER_CLOSE;
                end
                else if (last_reg)
                begin
                    dec.first = qfs_pkg::res_end(1'b1, qfs_pkg::ERR_MISSING_QUOTE);
                end
            end
            qfs_pkg::MODE_AFTER_CLOSE:
            begin
                mode_next = qfs_pkg::MODE_FIELD_START;
                if (byte_reg == separator)
                begin
                    dec.first = qfs_pkg::res_end(1'b0, qfs_pkg::ERR_NONE);
                    dec.two   = last_reg;
                end
                else
                begin
                    dec.first = qfs_pkg::res_end(last_reg, qfs_pkg::ERR_BAD_SEPARATOR);
                end
            end
            default:
            begin
                dec.first = fs_first;
                dec.two   = fs_two;
                mode_next = fs_mode;
            end
        endcase
        if (last_reg)
        begin
            mode_next = qfs_pkg::MODE_LINE_START;
        end
    end

endmodule

/* sv/qfs_result_queue.sv */
// Four-entry result queue that takes one or two results per cycle and
// drives the output channel. Depends on qfs_pkg and qfs_out_if.
module qfs_result_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  qfs_pkg::decode_t dec,
    output logic             room,
    qfs_out_if.source        out_ch
);

    qfs_pkg::result_t entry_reg [4];
    logic [1:0]       head_reg;
    logic [1:0]       tail_reg;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;
    logic             pop;
    logic [2:0]       push_n;

    assign room   = (count_reg <= 3'd2);
    assign pop    = out_ch.valid && out_ch.ready;
    assign push_n = dec.push ? (dec.two ? 3'd2 : 3'd1) : 3'd0;

    always_comb
    begin
        count_next = count_reg + push_n - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
            tail_reg  <= tail_reg + push_n[1:0];
            if (pop)
            begin
                head_reg <= head_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec.push)
        begin
            entry_reg[tail_reg] <= dec.first;
            if (dec.two)
            begin
                entry_reg[tail_reg + 2'd1] <= dec.second;
            end
        end
    end

    assign out_ch.valid      = (count_reg != 3'd0);
    assign out_ch.out_byte   = entry_reg[head_reg].out_byte;
    assign out_ch.field_end  = entry_reg[head_reg].field_end;
    assign out_ch.line_end   = entry_reg[head_reg].line_end;
    assign out_ch.error_code = entry_reg[head_reg].error_code;

endmodule

/* sv/quoted_field_splitter.sv */
// Top level of the quoted field splitter: configuration registers, parser
// and result queue. Depends on qfs_pkg, qfs_if, qfs_parser, qfs_result_queue.
//
// Line bytes enter on in_ch, one byte per transfer, last_byte set on the
// final byte of each line. Each byte yields zero, one or two results on
// out_ch: a field byte, or a field end marker that may carry line_end and
// an error code. Fields of a line that ends in error_code 1 are void.
// A byte is held in the input register until the queue has room; its results
// are then decoded into a four-entry result queue, from which out_ch offers
// them. One byte is taken per cycle while the queue has room for two results;
// out_ch delivers one result per cycle while the receiver is ready, so bytes
// that produce two results set the sustained pace. When the receiver stalls,
// the queue fills and in_ch.ready drops while the input register holds a byte
// and fewer than two free entries remain; nothing is lost.
// Reset empties the queue and the input register, puts the parser at the
// start of a line and restores quote_char to 34 and separator to 44.
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write them only while no line is in flight; the block does not enforce it.
module quoted_field_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    qfs_in_if.sink     in_ch,
    qfs_out_if.source  out_ch,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic [7:0]       quote_char_reg;
    logic [7:0]       separator_reg;
    qfs_pkg::decode_t dec;
    logic             room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_char_reg <= qfs_pkg::QUOTE_RESET;
            separator_reg  <= qfs_pkg::SEPARATOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index[0])
                qfs_pkg::REG_QUOTE_CHAR: quote_char_reg <= cfg_wdata;
                qfs_pkg::REG_SEPARATOR:  separator_reg  <= cfg_wdata;
                default:                 quote_char_reg <= quote_char_reg;
            endcase
        end
    end

    qfs_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .quote_char (quote_char_reg),
        .separator  (separator_reg),
        .room       (room),
        .dec        (dec)
    );

    qfs_result_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .dec    (dec),
        .room   (room),
        .out_ch (out_ch)
    );

    a_line_end_is_field_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.line_end |-> out_ch.field_end)
        else $error("line_end without field_end");

    a_error_on_field_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.error_code != qfs_pkg::ERR_NONE) |-> out_ch.field_end)
        else $error("error code on a field byte");

    a_missing_quote_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.error_code == qfs_pkg::ERR_MISSING_QUOTE)
        |-> out_ch.line_end)
        else $error("missing quote error not at line end");

    a_field_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.field_end |-> (out_ch.out_byte == 8'd0))
        else $error("field end carries a byte");

endmodule

/* tb/tb_quoted_field_splitter.sv */
// Self-checking testbench for quoted_field_splitter: drives lines of bytes with
// bursty input and a stalling receiver, predicts every result and compares them.
// Depends on qfs_pkg, qfs_if and the quoted_field_splitter RTL.
module tb_quoted_field_splitter;

    typedef logic [7:0] line_t[$];

    class field_split_tracker;
        logic [7:0]       quote_byte;
        logic [7:0]       sep_byte;
        qfs_pkg::mode_t   mode;
        qfs_pkg::result_t parsed_due[$];
        int               failures;

        function new();
            quote_byte = qfs_pkg::QUOTE_RESET;
            sep_byte   = qfs_pkg::SEPARATOR_RESET;
            mode       = qfs_pkg::MODE_LINE_START;
            failures   = 0;
        endfunction

        function void set_register(input logic idx, input logic [7:0] value);
            if (idx == qfs_pkg::REG_QUOTE_CHAR)
                quote_byte = value;
            else
                sep_byte = value;
        endfunction

        function void push_byte(input logic [7:0] b);
            qfs_pkg::result_t r;
            r.out_byte   = b;
            r.field_end  = 1'b0;
            r.line_end   = 1'b0;
            r.error_code = qfs_pkg::ERR_NONE;
            parsed_due = {parsed_due, r};
        endfunction

        function void push_end(input logic le, input logic [1:0] err);
            qfs_pkg::result_t r;
            r.out_byte   = 8'd0;
            r.field_end  = 1'b1;
            r.line_end   = le;
            r.error_code = err;
            parsed_due = {parsed_due, r};
        endfunction

        function void start_field(input logic [7:0] b, input logic last);
            if (b == quote_byte)
            begin
                if (last)
                    push_end(1'b1, qfs_pkg::ERR_MISSING_QUOTE);
                else
                begin
                    push_byte(b);
                    mode = qfs_pkg::MODE_QUOTED;
                end
            end
            else if (b == sep_byte)
            begin
                push_end(1'b0, qfs_pkg::ERR_NONE);
                mode = qfs_pkg::MODE_FIELD_START;
                if (last)
                    push_end(1'b1, qfs_pkg::ERR_NONE);
            end
            else
            begin
                push_byte(b);
                mode = qfs_pkg::MODE_UNQUOTED;
                if (last)
                    push_end(1'b1, qfs_pkg::ERR_NONE);
            end
        endfunction

        // Works out the results that one accepted byte must produce.
        function void take_byte(input logic [7:0] b, input logic last);
            case (mode)
                qfs_pkg::MODE_LINE_START:
                begin
                    if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
                    begin
                        if (!last)
                            mode = qfs_pkg::MODE_FIELD_START;
                        else
                        begin
                            if (b == sep_byte)
                                push_end(1'b0, qfs_pkg::ERR_NONE);
                            push_end(1'b1, qfs_pkg::ERR_NONE);
                        end
                    end
                    else
                        start_field(b, last);
                end
                qfs_pkg::MODE_UNQUOTED:
                begin
                    if (b == sep_byte)
                    begin
                        push_end(1'b0, qfs_pkg::ERR_NONE);
                        mode = qfs_pkg::MODE_FIELD_START;
                    end
                    else
                        push_byte(b);
                    if (last)
                        push_end(1'b1, qfs_pkg::ERR_NONE);
                end
                qfs_pkg::MODE_QUOTED:
                begin
                    if (b == quote_byte)
                    begin
                        push_byte(b);
                        mode = qfs_pkg::MODE_AFTER_CLOSE;
                        if (last)
                            push_end(1'b1, qfs_pkg::ERR_NONE);
                    end
                    else if (last)
                        push_end(1'b1, qfs_pkg::ERR_MISSING_QUOTE);
                    else
                        push_byte(b);
                end
                qfs_pkg::MODE_AFTER_CLOSE:
                begin
                    mode = qfs_pkg::MODE_FIELD_START;
                    if (b == sep_byte)
                    begin
                        push_end(1'b0, qfs_pkg::ERR_NONE);
                        if (last)
                            push_end(1'b1, qfs_pkg::ERR_NONE);
                    end
                    else
                        push_end(last, qfs_pkg::ERR_BAD_SEPARATOR);
                end
                default:
                    start_field(b, last);
            endcase
            if (last)
                mode = qfs_pkg::MODE_LINE_START;
        endfunction

        function void check_result(input qfs_pkg::result_t got);
            qfs_pkg::result_t want;
            if (parsed_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: byte %02h fe %0d le %0d err %0d",
                             got.out_byte, got.field_end, got.line_end, got.error_code);
                return;
            end
            want = parsed_due.pop_front();
            if (got.out_byte != want.out_byte || got.field_end != want.field_end ||
                got.line_end != want.line_end || got.error_code != want.error_code)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch: expected byte %02h fe %0d le %0d err %0d",
                             want.out_byte, want.field_end, want.line_end, want.error_code);
                    $display("          got      byte %02h fe %0d le %0d err %0d",
                             got.out_byte, got.field_end, got.line_end, got.error_code);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [0:0] cfg_index;
    logic [7:0] cfg_wdata;

    qfs_in_if  in_ch();
    qfs_out_if out_ch();

    quoted_field_splitter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    field_split_tracker sb;
    qfs_pkg::result_t   seen_result;
    int                 burst_left = 0;
    int                 bytes_sent = 0;
    bit                 hold_request = 1'b0;
    int                 hold_left = 0;
    int                 stall_phase = 0;
    int                 stall_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("tb_quoted_field_splitter: errors");
        $finish;
    end

    // The receiver cycles through stall rates and honors one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_left    = 400;
            hold_request = 1'b0;
        end
        stall_phase = (stall_phase + 1) % 240;
        case (stall_phase / 60)
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            2:       stall_pct = 60;
            default: stall_pct = 85;
        endcase
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen_result.out_byte   = out_ch.out_byte;
            seen_result.field_end  = out_ch.field_end;
            seen_result.line_end   = out_ch.line_end;
            seen_result.error_code = out_ch.error_code;
            sb.check_result(seen_result);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.take_byte(b, last);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_line(input line_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Stops the input and waits until the block has nothing left in flight.
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.parsed_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, value);
    endtask

    function automatic logic [7:0] any_byte(input logic [7:0] q, input logic [7:0] s);
        case ($urandom_range(0, 3))
            0:       return q;
            1:       return s;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] q, input logic [7:0] s);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == q || b == s);
        return b;
    endfunction

    // Mostly well-formed lines of quoted and plain fields; some corrupted, some pure noise.
    function automatic line_t make_line(input logic [7:0] q, input logic [7:0] s);
        line_t      line;
        int         kind;
        int         fields;
        int         len;
        logic [7:0] ws;
        kind = $urandom_range(0, 9);
        if (kind >= 8)
        begin
            len = $urandom_range(1, 8);
            repeat (len) line = {line, any_byte(q, s)};
            return line;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            ws = 8'($urandom_range(9, 14));
            line = {line, (ws == 8'd14) ? 8'h20 : ws};
        end
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++)
        begin
            if (f > 0)
                line = {line, s};
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 1))
            begin
                line = {line, q};
                repeat (len) line = {line, plain_byte(q, s)};
                line = {line, q};
            end
            else
                repeat (len) line = {line, plain_byte(q, s)};
        end
        if (line.size() == 0)
            line = {line, s};
        if (kind == 7)
            line[$urandom_range(0, line.size() - 1)] = any_byte(q, s);
        return line;
    endfunction

    initial
    begin
        int         phase_start;
        logic [7:0] q;
        logic [7:0] s;
        sb              = new();
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = qfs_pkg::REG_QUOTE_CHAR;
        cfg_wdata       = 8'd0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_line({8'h20, 8'h78, 8'h2C});
        send_line({8'h00, 8'hFF});
        send_line({8'h22, 8'h61, 8'h2C, 8'h22, 8'h71});
        send_line({8'h22});
        send_line({8'h22, 8'h62});
        send_line({8'h09});
        send_line({8'h2C});
        send_line({8'h22, 8'h22});
        send_line({8'h61, 8'h22, 8'h62});
        settle();
        write_reg(qfs_pkg::REG_SEPARATOR, 8'h20);
        send_line({8'h20});
        send_line({8'h20, 8'h61});
        settle();
        write_reg(qfs_pkg::REG_QUOTE_CHAR, 8'h3B);
        write_reg(qfs_pkg::REG_SEPARATOR, 8'h3B);
        send_line({8'h3B, 8'h61, 8'h3B});
        send_line({8'h61, 8'h3B, 8'h62});

        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    q = qfs_pkg::QUOTE_RESET;
                    s = qfs_pkg::SEPARATOR_RESET;
                end
                1:
                begin
                    q = 8'h00;
                    s = 8'hFF;
                end
                2:
                begin
                    q = 8'hFF;
                    s = 8'h00;
                end
                3:
                begin
                    q = 8'($urandom_range(0, 255));
                    s = q;
                end
                4:
                begin
                    q = 8'h20;
                    s = 8'h09;
                end
                default:
                begin
                    q = 8'($urandom_range(0, 255));
                    s = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(qfs_pkg::REG_QUOTE_CHAR, q);
            write_reg(qfs_pkg::REG_SEPARATOR, s);
            if (phase == 2)
                hold_request = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 60)
                send_line(make_line(q, s));
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.parsed_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0)
            $display("tb_quoted_field_splitter: clean");
        else
            $display("tb_quoted_field_splitter: errors");
        $finish;
    end

endmodule
